// ===== rtl/core/hotp_pkg.sv =====
// Package: constants and helper functions for the HOTP code generator.
package hotp_pkg;

  localparam int MaxKeyBytes = 32;
  localparam int KeyWords    = 4;
  localparam int KeyWordW    = 64;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;
  localparam int CounterW    = 64;
  localparam int PasswordW   = 30;
  localparam int KeyLenW     = 6;
  localparam int DigitsW     = 4;

  localparam logic [CfgIdxW-1:0] REG_KEY0    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_LEN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DIGITS  = 3'd5;

  localparam logic [KeyLenW-1:0] KEY_LEN_RESET = 6'd20;
  localparam logic [DigitsW-1:0] DIGITS_RESET  = 4'd6;

  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;

  // Round constant by round number.
  function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20)      k = 32'h5A827999;
    else if (rnd < 7'd40) k = 32'h6ED9EBA1;
    else if (rnd < 7'd60) k = 32'h8F1BBCDC;
    else                  k = 32'hCA62C1D6;
    return k;
  endfunction

  // Round logic function by round number.
  function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20)      f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                  f = b ^ c ^ d;
    return f;
  endfunction

  // Ten to the power n, n clipped to 9.
  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/hotp_if.sv =====
// Interfaces: valid/ready channels for counters and passwords.
interface hotp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] counter;
  modport source (output valid, output counter, input ready);
  modport sink   (input valid, input counter, output ready);
endinterface

interface hotp_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] password;
  modport source (output valid, output password, input ready);
  modport sink   (input valid, input password, output ready);
endinterface

// ===== rtl/core/hotp_code_generator_unit.sv =====
// Top level: HOTP (HMAC-SHA1) one-time password generator.
//
//  channel | dir | payload              | handshake
//  in      | in  | counter[63:0]        | in.valid / in.ready
//  out     | out | password[29:0]       | out.valid / out.ready
//  cfg     | in  | idx[2:0], data[63:0] | cfg_we, no wait
//
// Per counter: four SHA-1 compressions, each a message-load phase of 16 words,
// 80 rounds through one shared round unit and an add-back step, then dynamic
// truncation and a bit-serial remainder of 31 steps.
// The block takes no counter while one is in work; the result register holds
// the password until out.ready, then in.ready returns. Reset is synchronous.
module hotp_code_generator_unit #(
  parameter int MAX_KEY_BYTES = hotp_pkg::MaxKeyBytes
) (
  input  logic                         clk,
  input  logic                         rst_n,
  hotp_in_if.sink                      in,
  hotp_out_if.source                   out,
  input  logic                         cfg_we,
  input  logic [hotp_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [hotp_pkg::CfgDataW-1:0] cfg_data
);
  import hotp_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_ROUND = 7'b0000100,
    ST_ADD   = 7'b0001000,
    ST_TRUNC = 7'b0010000,
    ST_MOD   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // Configuration registers
  logic [KeyWordW-1:0] key_r [KeyWords];
  logic [KeyLenW-1:0]  key_len_r;
  logic [DigitsW-1:0]  digits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KeyWords; i++) key_r[i] <= '0;
      key_len_r <= KEY_LEN_RESET;
      digits_r  <= DIGITS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KEY0:    key_r[0]  <= cfg_data;
        REG_KEY1:    key_r[1]  <= cfg_data;
        REG_KEY2:    key_r[2]  <= cfg_data;
        REG_KEY3:    key_r[3]  <= cfg_data;
        REG_KEY_LEN: key_len_r <= cfg_data[KeyLenW-1:0];
        REG_DIGITS:  digits_r  <= cfg_data[DigitsW-1:0];
        default: ;
      endcase
    end
  end

  // Effective key length, clipped to the parameter
  localparam int KlenMax = (MAX_KEY_BYTES < 64) ? MAX_KEY_BYTES : 64;
  logic [6:0] klen;
  assign klen = ({1'b0, key_len_r} > 7'(KlenMax)) ? 7'(KlenMax) : {1'b0, key_len_r};

  // Sequencer state
  state_t      state_r, state_nxt;
  logic [6:0]  cnt_r;      // word index / round / mod step
  logic [1:0]  blk_r;      // 0 inner key, 1 inner msg, 2 outer key, 3 outer msg
  logic [63:0] ctr_r;
  logic [159:0] h_r;       // chaining value
  logic [159:0] inner_r;   // inner digest
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];   // message schedule window
  logic [30:0] code_r;
  logic [29:0] rem_r;
  logic [29:0] pw_r;
  logic        out_valid_r;

  // Word t of the padded key block: key bytes at or past the key length are zeroed, then XORed with the pad
  function automatic logic [31:0] key_word32(input logic [3:0] t, input logic [6:0] kl,
                                             input logic [7:0] pad,
                                             input logic [63:0] k0, input logic [63:0] k1,
                                             input logic [63:0] k2, input logic [63:0] k3);
    logic [31:0] wv;
    logic [7:0]  bv;
    logic [5:0]  idx;
    logic [63:0] kw;
    wv = '0;
    for (int j = 0; j < 4; j++) begin
      idx = {t, 2'(j)};
      case (idx[4:3])
        2'd0:    kw = k0;
        2'd1:    kw = k1;
        2'd2:    kw = k2;
        default: kw = k3;
      endcase
      bv = kw[8*(7-idx[2:0]) +: 8];
      if (idx[5] || ({1'b0, idx} >= kl)) bv = '0;
      wv[8*(3-j) +: 8] = bv ^ pad;
    end
    return wv;
  endfunction

  logic [31:0] load_w;
  always_comb begin
    load_w = '0;
    case (blk_r)
      2'd0: load_w = key_word32(cnt_r[3:0], klen, IPAD, key_r[0], key_r[1], key_r[2], key_r[3]);
      2'd2: load_w = key_word32(cnt_r[3:0], klen, OPAD, key_r[0], key_r[1], key_r[2], key_r[3]);
      2'd1: begin
        case (cnt_r[3:0])
          4'd0:    load_w = ctr_r[63:32];
          4'd1:    load_w = ctr_r[31:0];
          4'd2:    load_w = 32'h80000000;
          4'd15:   load_w = 32'd576;
          default: load_w = '0;
        endcase
      end
      default: begin
        if (cnt_r[3:0] < 4'd5) load_w = inner_r[32*(4-cnt_r[2:0]) +: 32];
        else if (cnt_r[3:0] == 4'd5) load_w = 32'h80000000;
        else if (cnt_r[3:0] == 4'd15) load_w = 32'd672;
        else load_w = '0;
      end
    endcase
  end

  // Shared round unit
  logic [31:0] w_cur, w_new, t_sum;
  assign w_cur = (cnt_r < 7'd16) ? w_r[0] : w_new;
  always_comb begin
    logic [31:0] x;
    x = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {x[30:0], x[31]};
  end
  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1_f(cnt_r, b_r, c_r, d_r) + e_r +
                 sha1_k(cnt_r) + w_cur;

  // Dynamic truncation
  logic [3:0]  off;
  logic [30:0] trunc;
  always_comb begin
    logic [159:0] dg;
    dg = h_r;
    off = dg[3:0];
    trunc = 31'(dg[159 - 8*off -: 32]);
  end

  // Bit-serial remainder: one code bit per step
  logic [29:0] modulus;
  logic [30:0] rem_sh;
  assign modulus = pow10(digits_r);
  assign rem_sh  = {rem_r, code_r[30]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in.valid) state_nxt = ST_LOAD;
      ST_LOAD:  if (cnt_r == 7'd15) state_nxt = ST_ROUND;
      ST_ROUND: if (cnt_r == 7'd79) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = (blk_r == 2'd3) ? ST_TRUNC : ST_LOAD;
      ST_TRUNC: state_nxt = ST_MOD;
      ST_MOD:   if (cnt_r == 7'd30) state_nxt = ST_DONE;
      ST_DONE:  if (out.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          blk_r <= '0;
        end
        ST_LOAD:  cnt_r <= (cnt_r == 7'd15) ? 7'd0 : cnt_r + 7'd1;
        ST_ROUND: cnt_r <= (cnt_r == 7'd79) ? 7'd0 : cnt_r + 7'd1;
        ST_ADD:   begin
          blk_r <= blk_r + 2'd1;
          cnt_r <= '0;
        end
        ST_TRUNC: cnt_r <= '0;
        ST_MOD:   begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd30) out_valid_r <= 1'b1;
        end
        ST_DONE:  if (out.ready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in.valid) ctr_r <= in.counter;
        h_r <= SHA1_IV;
      end
      ST_LOAD: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= load_w;
        if (blk_r == 2'd2 && cnt_r == 7'd0) h_r <= SHA1_IV;
        if (cnt_r == 7'd15) begin
          a_r <= (blk_r == 2'd2 && cnt_r == 7'd0) ? SHA1_IV[159:128] : h_r[159:128];
          b_r <= h_r[127:96];
          c_r <= h_r[95:64];
          d_r <= h_r[63:32];
          e_r <= h_r[31:0];
        end
      end
      ST_ROUND: begin
        if (cnt_r >= 7'd16) begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
        end else begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_r[0];
        end
        e_r <= d_r;
        d_r <= c_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        b_r <= a_r;
        a_r <= t_sum;
      end
      ST_ADD: begin
        h_r <= {h_r[159:128] + a_r, h_r[127:96] + b_r, h_r[95:64] + c_r,
                h_r[63:32] + d_r, h_r[31:0] + e_r};
        if (blk_r == 2'd1)
          inner_r <= {h_r[159:128] + a_r, h_r[127:96] + b_r, h_r[95:64] + c_r,
                      h_r[63:32] + d_r, h_r[31:0] + e_r};
      end
      ST_TRUNC: begin
        code_r <= trunc;
        rem_r  <= '0;
      end
      ST_MOD: begin
        code_r <= {code_r[29:0], 1'b0};
        if (rem_sh >= {1'b0, modulus}) rem_r <= 30'(rem_sh - {1'b0, modulus});
        else rem_r <= rem_sh[29:0];
        if (cnt_r == 7'd30) begin
          if (rem_sh >= {1'b0, modulus}) pw_r <= 30'(rem_sh - {1'b0, modulus});
          else pw_r <= rem_sh[29:0];
        end
      end
      default: ;
    endcase
  end

  assign in.ready     = (state_r == ST_IDLE);
  assign out.valid    = out_valid_r;
  assign out.password = pw_r;

endmodule

// ===== rtl/core/hotp_checker.sv =====
// Checker: port-level properties of the HOTP generator, bound to the top level.
module hotp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [29:0] out_password
);
  // No new counter while a password waits
  a_busy_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready with result pending");
  // A transfer in makes the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  // Stalled password holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_password)))
    else $error("result changed under stall");
  // Output transfer frees the block
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (!out_valid && in_ready)) else $error("not freed");
endmodule

bind hotp_code_generator_unit hotp_checker u_hotp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .out_password(out.password)
);

// ===== tb/password_checker.sv =====
// Checker: watches the counter, password and register ports, predicts each password and compares.
`timescale 1ns / 100ps
module password_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  hotp_in_if                            in_ch,
  hotp_out_if                           out_ch,
  input  logic                          cfg_we,
  input  logic [hotp_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [hotp_pkg::CfgDataW-1:0] cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            passwords_seen
);
  import hotp_pkg::*;

  // shadow copy of the key and format registers
  logic [KeyWordW-1:0]  key_word_q [KeyWords];
  logic [KeyLenW-1:0]   key_len_q;
  logic [DigitsW-1:0]   digits_q;
  logic [PasswordW-1:0] passwords_due [$];

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one SHA-1 compression of a 512-bit block
  function automatic logic [159:0] sha1_block(input logic [159:0] hv, input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = hv;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d, hv[31:0] + e};
  endfunction

  // HMAC-SHA1 of the counter, dynamic truncation, then modulo 10^digits
  function automatic logic [PasswordW-1:0] expected_password(input logic [CounterW-1:0] ctr);
    logic [511:0] kblk;
    logic [159:0] hv, inner, dig;
    logic [31:0]  code;
    logic [3:0]   off;
    int           klen, ndig;
    longint       modulus;
    kblk = '0;
    klen = (key_len_q > MaxKeyBytes) ? MaxKeyBytes : key_len_q;
    for (int i = 0; i < klen; i++)
      kblk[511-8*i -: 8] = key_word_q[i/8][63-8*(i%8) -: 8];
    hv = sha1_block(SHA1_IV, kblk ^ {64{IPAD}});
    inner = sha1_block(hv, {ctr, 8'h80, 376'd0, 64'd576});
    hv = sha1_block(SHA1_IV, kblk ^ {64{OPAD}});
    dig = sha1_block(hv, {inner, 8'h80, 280'd0, 64'd672});
    off = dig[3:0];
    code = dig[159-8*off -: 32] & 32'h7fffffff;
    ndig = (digits_q > 9) ? 9 : digits_q;
    modulus = 1;
    for (int i = 0; i < ndig; i++) modulus *= 10;
    return PasswordW'(longint'(code) % modulus);
  endfunction

  assign pending = passwords_due.size();

  always @(posedge clk) begin
    logic [PasswordW-1:0] exp_pw;
    if (!rst_n) begin
      foreach (key_word_q[i]) key_word_q[i] <= '0;
      key_len_q <= KEY_LEN_RESET;
      digits_q  <= DIGITS_RESET;
      passwords_due.delete();
      mismatches <= 0;
      passwords_seen <= 0;
    end else begin
      // register writes only happen while idle, so ordering vs. transfers is moot
      if (cfg_we) begin
        case (cfg_idx)
          REG_KEY0:    key_word_q[0] <= cfg_data;
          REG_KEY1:    key_word_q[1] <= cfg_data;
          REG_KEY2:    key_word_q[2] <= cfg_data;
          REG_KEY3:    key_word_q[3] <= cfg_data;
          REG_KEY_LEN: key_len_q <= cfg_data[KeyLenW-1:0];
          REG_DIGITS:  digits_q  <= cfg_data[DigitsW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) passwords_due.push_back(expected_password(in_ch.counter));
      if (out_ch.valid && out_ch.ready) begin
        passwords_seen <= passwords_seen + 1;
        if (passwords_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("password %0d with no counter outstanding", out_ch.password);
        end else begin
          exp_pw = passwords_due.pop_front();
          if (exp_pw !== out_ch.password) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("password mismatch: expected %0d, got %0d", exp_pw, out_ch.password);
          end
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, counter and register stimulus, verdict.
`timescale 1ns / 100ps
module testbench;
  import hotp_pkg::*;

  localparam int IdleLimit = 6000;
  localparam int RandPhases = 8;
  localparam int PhaseItems = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic quiet = 1'b0;
  int mismatches, pending, passwords_seen, counters_sent, idle_cycles;
  int ready_hold;

  hotp_in_if  in_ch ();
  hotp_out_if out_ch ();

  hotp_code_generator_unit u_top (
    .clk(clk), .rst_n(rst_n), .in(in_ch), .out(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  password_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .passwords_seen(passwords_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.counter = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stall bursts, none in the quiet tail
  always @(negedge clk) begin
    if (quiet) out_ch.ready = 1'b1;
    else if (ready_hold > 0) ready_hold--;
    else if ($urandom_range(3) == 0) begin
      out_ch.ready = 1'b0;
      ready_hold = $urandom_range(0, 5);
    end else out_ch.ready = 1'b1;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[hotp_code_generator_unit] ERROR");
      $finish;
    end
  end

  task automatic send_counter(input logic [CounterW-1:0] ctr);
    if (!quiet && $urandom_range(2) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.counter = ctr;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    counters_sent++;
    @(negedge clk);
  endtask

  // wait until every password is back, then let the block settle
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_key(input logic [63:0] k0, input logic [63:0] k1, input logic [63:0] k2,
                         input logic [63:0] k3, input int klen, input int ndig);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_KEY_LEN, CfgDataW'(klen));
    write_reg(REG_DIGITS, CfgDataW'(ndig));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset settings, counter extremes
    send_counter(64'd0);
    send_counter('1);
    send_counter(64'h5555_5555_5555_5555);
    send_counter(64'hAAAA_AAAA_AAAA_AAAA);
    send_counter(64'd1);
    send_counter(64'h8000_0000_0000_0000);
    drain();
    // full-length all-ones key, nine digits
    set_key('1, '1, '1, '1, 32, 9);
    send_counter(64'd0);
    send_counter('1);
    drain();
    // oversized key length and digit count get clipped
    set_key(rand64(), rand64(), rand64(), rand64(), 63, 15);
    send_counter(64'd7);
    send_counter(rand64());
    drain();
    // empty key, zero digits
    set_key(rand64(), rand64(), rand64(), rand64(), 0, 0);
    send_counter(64'd2);
    send_counter(rand64());
    drain();
    // one key byte, one digit
    set_key(64'hFF00_0000_0000_0000, '0, '0, '0, 1, 1);
    send_counter(64'd3);
    send_counter(rand64());
    drain();

    // random phases, each with a fresh setting; the last one without stalls
    for (int p = 0; p < RandPhases; p++) begin
      set_key(rand64(), rand64(), rand64(), rand64(),
              ($urandom_range(3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 32),
              ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 9));
      quiet = (p == RandPhases - 1);
      for (int i = 0; i < PhaseItems; i++) send_counter(rand64());
      drain();
    end

    $display("%0d counters sent, %0d passwords checked over %0d register settings",
             counters_sent, passwords_seen, RandPhases + 5);
    if (mismatches == 0 && pending == 0) $display("[hotp_code_generator_unit] OK");
    else $display("[hotp_code_generator_unit] ERROR");
    $finish;
  end
endmodule
